@@ rtl/core/utt_pkg.sv @@
`timescale 1ns / 1ps

package utt_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [20:0] REPLACEMENT_CHAR = 21'h00fffd;
    localparam logic [15:0] HIGH_SURR_FIRST  = 16'hd800;
    localparam logic [15:0] HIGH_SURR_LAST   = 16'hdbff;
    localparam logic [15:0] LOW_SURR_FIRST   = 16'hdc00;
    localparam logic [15:0] LOW_SURR_LAST    = 16'hdfff;
    localparam logic [20:0] SUPPLEMENTARY    = 21'h010000;
    localparam logic [31:0] MAX_CODE_POINT   = 32'h0010ffff;
    localparam logic [7:0]  LEAD_TWO         = 8'hc0;
    localparam logic [7:0]  LEAD_THREE       = 8'he0;
    localparam logic [7:0]  LEAD_FOUR        = 8'hf0;
    localparam logic [7:0]  CONT_MARK        = 8'h80;

    typedef struct packed {
        logic [31:0] code_unit;
        logic        string_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       run_last;
        logic       string_last;
    } t_out_item;

    // one queued job: one or two code points for the back end to encode
    typedef struct packed {
        logic        two_pts;
        logic [20:0] cp_a;
        logic [20:0] cp_b;
        logic        str_end;
    } t_job;

    function automatic logic [20:0] sanitize(input logic [31:0] cp);
        logic [20:0] res;
        if (cp > MAX_CODE_POINT ||
            (cp >= {16'h0, HIGH_SURR_FIRST} && cp <= {16'h0, LOW_SURR_LAST})) begin
            res = REPLACEMENT_CHAR;
        end else begin
            res = cp[20:0];
        end
        return res;
    endfunction

    // number of bytes minus one
    function automatic logic [1:0] cp_len(input logic [20:0] cp);
        logic [1:0] res;
        if (cp <= 21'h7f) begin
            res = 2'd0;
        end else if (cp <= 21'h7ff) begin
            res = 2'd1;
        end else if (cp <= 21'hffff) begin
            res = 2'd2;
        end else begin
            res = 2'd3;
        end
        return res;
    endfunction

    function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [1:0] len,
                                            input logic [1:0] idx);
        logic [7:0] res;
        res = CONT_MARK | {2'b00, cp[5:0]};
        unique case (len)
            2'd0: res = cp[7:0];
            2'd1: begin
                if (idx == 2'd0) res = LEAD_TWO | {3'b000, cp[10:6]};
            end
            2'd2: begin
                if (idx == 2'd0) res = LEAD_THREE | {4'b0000, cp[15:12]};
                else if (idx == 2'd1) res = CONT_MARK | {2'b00, cp[11:6]};
            end
            default: begin
                if (idx == 2'd0) res = LEAD_FOUR | {5'b00000, cp[20:18]};
                else if (idx == 2'd1) res = CONT_MARK | {2'b00, cp[17:12]};
                else if (idx == 2'd2) res = CONT_MARK | {2'b00, cp[11:6]};
            end
        endcase
        return res;
    endfunction

endpackage

@@ rtl/core/utt_front.sv @@
`timescale 1ns / 1ps

module utt_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  utt_pkg::t_in_item i_in_item,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_data,
    input  logic             i_q_full,
    output logic             o_push,
    output utt_pkg::t_job    o_job
);
    import utt_pkg::*;

    logic        r_sixteen;
    logic        r_held_valid;
    logic [9:0]  r_held_high;
    logic        n_held_valid;
    logic [9:0]  n_held_high;
    logic        accept;
    logic [15:0] unit16;
    logic        is_low;
    logic        is_high;
    logic        last;

    assign o_in_ready  = !i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !i_q_full;
    assign unit16      = i_in_item.code_unit[15:0];
    assign last        = i_in_item.string_end;
    assign is_low      = unit16 >= LOW_SURR_FIRST && unit16 <= LOW_SURR_LAST;
    assign is_high     = unit16 >= HIGH_SURR_FIRST && unit16 <= HIGH_SURR_LAST;

    always_comb begin
        n_held_valid  = r_held_valid;
        n_held_high   = r_held_high;
        o_push        = 1'b0;
        o_job.two_pts = 1'b0;
        o_job.cp_a    = sanitize(i_in_item.code_unit);
        o_job.cp_b    = sanitize({16'h0, unit16});
        o_job.str_end = last;
        if (r_sixteen) begin
            o_job.cp_a = sanitize({16'h0, unit16});
            if (r_held_valid && is_low) begin
                n_held_valid = 1'b0;
                n_held_high  = '0;
                o_push       = accept;
                o_job.cp_a   = SUPPLEMENTARY + {1'b0, r_held_high, unit16[9:0]};
            end else if (is_high && !last) begin
                // pending surrogate is replaced, the new one is held
                n_held_valid = 1'b1;
                n_held_high  = unit16[9:0];
                o_push       = accept && r_held_valid;
                o_job.cp_a   = REPLACEMENT_CHAR;
            end else begin
                n_held_valid  = 1'b0;
                n_held_high   = '0;
                o_push        = accept;
                o_job.two_pts = r_held_valid;
                if (r_held_valid) o_job.cp_a = REPLACEMENT_CHAR;
            end
        end else begin
            o_push = accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sixteen    <= 1'b1;
            r_held_valid <= 1'b0;
            r_held_high  <= '0;
        end else if (i_cfg_valid) begin
            r_sixteen    <= i_cfg_data;
            r_held_valid <= 1'b0;
            r_held_high  <= '0;
        end else if (accept) begin
            r_held_valid <= n_held_valid;
            r_held_high  <= n_held_high;
        end
    end

endmodule

@@ rtl/core/utt_queue.sv @@
`timescale 1ns / 1ps

module utt_queue #(
    parameter int unsigned DEPTH = utt_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  utt_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output utt_pkg::t_job o_job
);
    import utt_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

endmodule

@@ rtl/core/utt_back.sv @@
`timescale 1ns / 1ps

module utt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  utt_pkg::t_job     i_job,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output utt_pkg::t_out_item o_out_item
);
    import utt_pkg::*;

    logic        r_phase;
    logic [1:0]  r_idx;
    logic        r_out_valid;
    t_out_item   r_out_item;
    logic        n_phase;
    logic [1:0]  n_idx;
    logic [20:0] cur_cp;
    logic [1:0]  cur_len;
    logic        pt_done;
    logic        last_pt;
    logic        load;

    assign cur_cp  = r_phase ? i_job.cp_b : i_job.cp_a;
    assign cur_len = cp_len(cur_cp);
    assign pt_done = r_idx == cur_len;
    assign last_pt = !i_job.two_pts || r_phase;
    assign load    = i_job_valid && (!r_out_valid || i_out_ready);
    assign o_pop   = load && pt_done && last_pt;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx + 2'd1;
        if (pt_done) begin
            n_idx   = '0;
            n_phase = !last_pt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_item.utf8_byte   <= enc_byte(cur_cp, cur_len, r_idx);
            r_out_item.run_last    <= pt_done && last_pt;
            r_out_item.string_last <= pt_done && last_pt && i_job.str_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_phase     <= n_phase;
                r_idx       <= n_idx;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/core/utf16_to_utf8_transcoder_core.sv @@
`timescale 1ns / 1ps

// UTF-16 / UTF-32 to UTF-8 transcoder. Each input transaction carries one code unit and
// an end-of-string flag; the block returns the UTF-8 bytes one per output transaction,
// with run_last on the final byte of the unit and string_last on the final byte of a
// string. The output runs at one byte per cycle while the queue holds a job and the receiver
// is ready; a unit yields one to four bytes (up to six when a dangling high surrogate is
// replaced), and a held high surrogate yields no output. Input is taken every cycle while the job
// queue between the classifier and the byte encoder has room. A configuration write
// (1 = UTF-16 with surrogate pairing, 0 = 32-bit code points; reset 1) drops any held
// surrogate and must only be issued while the block is idle.
module utf16_to_utf8_transcoder_core #(
    parameter int unsigned QUEUE_DEPTH = utt_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  utt_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output utt_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);
    import utt_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_job push_job;
    t_job head_job;

    utt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (push_job)
    );

    utt_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_job  (push_job),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_job  (head_job)
    );

    utt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(q_valid),
        .i_job      (head_job),
        .o_pop      (q_pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

endmodule

@@ sim/tb_utf16_to_utf8_transcoder_core.sv @@
`timescale 1ns / 1ps

module tb_utf16_to_utf8_transcoder_core;
    import utt_pkg::*;

    localparam int SETTLE_CYCLES  = 12;
    localparam int RX_HOLD_CYCLES = 150;
    localparam int DIR_COUNT      = 26;

    typedef struct packed {
        logic        is_cfg;
        logic        typed;
        logic [31:0] unit;
        logic        str_end;
        logic [2:0]  n_bytes;
        logic [47:0] bytes;
    } t_dir_row;

    // typed rows carry their bytes left-aligned, first byte in the top octet
    localparam t_dir_row DIR_ROWS [0:DIR_COUNT-1] = '{
        '{1'b0, 1'b1, 32'h0000_0000, 1'b0, 3'd1, 48'h00_0000000000},
        '{1'b0, 1'b1, 32'h0000_007f, 1'b1, 3'd1, 48'h7f_0000000000},
        '{1'b0, 1'b1, 32'h0000_0080, 1'b0, 3'd2, 48'hc280_00000000},
        '{1'b0, 1'b1, 32'h0000_07ff, 1'b0, 3'd2, 48'hdfbf_00000000},
        '{1'b0, 1'b1, 32'h0000_0800, 1'b0, 3'd3, 48'he0a080_000000},
        '{1'b0, 1'b1, 32'h0000_ffff, 1'b1, 3'd3, 48'hefbfbf_000000},
        '{1'b0, 1'b1, 32'h0000_d800, 1'b0, 3'd0, 48'h0},
        '{1'b0, 1'b1, 32'h0000_dc00, 1'b1, 3'd4, 48'hf0908080_0000},
        '{1'b0, 1'b1, 32'h0000_dbff, 1'b0, 3'd0, 48'h0},
        '{1'b0, 1'b1, 32'h0000_dfff, 1'b0, 3'd4, 48'hf48fbfbf_0000},
        '{1'b0, 1'b1, 32'h0000_dc00, 1'b1, 3'd3, 48'hefbfbd_000000},
        '{1'b0, 1'b1, 32'h0000_d83d, 1'b1, 3'd3, 48'hefbfbd_000000},
        '{1'b0, 1'b0, 32'h0000_d800, 1'b0, 3'd0, 48'h0},
        '{1'b0, 1'b0, 32'h0000_0041, 1'b1, 3'd0, 48'h0},
        '{1'b0, 1'b0, 32'h0000_d800, 1'b0, 3'd0, 48'h0},
        '{1'b0, 1'b0, 32'h0000_d801, 1'b0, 3'd0, 48'h0},
        '{1'b0, 1'b0, 32'h0000_20ac, 1'b1, 3'd0, 48'h0},
        '{1'b0, 1'b0, 32'hffff_0041, 1'b0, 3'd0, 48'h0},
        '{1'b0, 1'b0, 32'h0000_dbff, 1'b0, 3'd0, 48'h0},
        '{1'b1, 1'b0, 32'h0000_0000, 1'b0, 3'd0, 48'h0},
        '{1'b0, 1'b1, 32'h0010_ffff, 1'b0, 3'd4, 48'hf48fbfbf_0000},
        '{1'b0, 1'b1, 32'h0011_0000, 1'b0, 3'd3, 48'hefbfbd_000000},
        '{1'b0, 1'b1, 32'hffff_ffff, 1'b1, 3'd3, 48'hefbfbd_000000},
        '{1'b0, 1'b0, 32'h0000_dc00, 1'b0, 3'd0, 48'h0},
        '{1'b0, 1'b0, 32'h0001_f600, 1'b1, 3'd0, 48'h0},
        '{1'b1, 1'b0, 32'h0000_0001, 1'b0, 3'd0, 48'h0}
    };

    localparam logic [31:0] BOUNDARY_POINTS [0:9] = '{
        32'h0000_007f, 32'h0000_0080, 32'h0000_07ff, 32'h0000_0800, 32'h0000_d7ff,
        32'h0000_e000, 32'h0000_ffff, 32'h0001_0000, 32'h0010_ffff, 32'h0011_0000
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       o_in_ready;
    t_in_item   in_item = '0;
    logic       o_out_valid;
    logic       out_ready = 1'b0;
    t_out_item  o_out_item;
    logic       cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       cfg_data = 1'b0;

    int         tx_idle_pct = 19;
    int         rx_idle_pct = 50;
    logic       rx_hold_req = 1'b0;
    int         rx_holds = 0;
    int         units_sent = 0;
    int         bytes_checked = 0;
    int         mode_writes = 0;
    int         mismatches = 0;

    // transcoder state as seen by the checker
    logic       mdl_sixteen;
    logic [9:0] mdl_held_high;
    logic       mdl_held_valid;
    logic [7:0] unit_bytes[$];
    t_out_item  utf8_due[$];

    always #5 clk = ~clk;

    utf16_to_utf8_transcoder_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    task automatic add_byte(input logic [7:0] b);
        unit_bytes.insert(unit_bytes.size(), b);
    endtask

    task automatic append_point(input logic [31:0] cp_in);
        logic [31:0] cp;
        cp = cp_in;
        if (cp > MAX_CODE_POINT ||
            (cp >= {16'h0, HIGH_SURR_FIRST} && cp <= {16'h0, LOW_SURR_LAST})) begin
            cp = {11'h0, REPLACEMENT_CHAR};
        end
        if (cp <= 32'h7f) begin
            add_byte(cp[7:0]);
        end else if (cp <= 32'h7ff) begin
            add_byte(LEAD_TWO | {3'b000, cp[10:6]});
            add_byte(CONT_MARK | {2'b00, cp[5:0]});
        end else if (cp <= 32'hffff) begin
            add_byte(LEAD_THREE | {4'b0000, cp[15:12]});
            add_byte(CONT_MARK | {2'b00, cp[11:6]});
            add_byte(CONT_MARK | {2'b00, cp[5:0]});
        end else begin
            add_byte(LEAD_FOUR | {5'b00000, cp[20:18]});
            add_byte(CONT_MARK | {2'b00, cp[17:12]});
            add_byte(CONT_MARK | {2'b00, cp[11:6]});
            add_byte(CONT_MARK | {2'b00, cp[5:0]});
        end
    endtask

    task automatic transcode_unit(input t_in_item it);
        logic [15:0] u16;
        logic        is_low;
        logic        is_high;
        unit_bytes.delete();
        if (mdl_sixteen) begin
            u16 = it.code_unit[15:0];
            is_low = u16 >= LOW_SURR_FIRST && u16 <= LOW_SURR_LAST;
            is_high = u16 >= HIGH_SURR_FIRST && u16 <= HIGH_SURR_LAST;
            if (mdl_held_valid && is_low) begin
                mdl_held_valid = 1'b0;
                append_point({11'h0, SUPPLEMENTARY} + {12'h0, mdl_held_high, 10'h0}
                             + {16'h0, u16 - LOW_SURR_FIRST});
                mdl_held_high = '0;
            end else begin
                if (mdl_held_valid) begin
                    mdl_held_valid = 1'b0;
                    mdl_held_high = '0;
                    append_point({11'h0, REPLACEMENT_CHAR});
                end
                if (is_high && !it.string_end) begin
                    mdl_held_high = u16[9:0];
                    mdl_held_valid = 1'b1;
                end else begin
                    append_point({16'h0, u16});
                end
            end
        end else begin
            append_point(it.code_unit);
        end
    endtask

    task automatic send_item(input logic [31:0] unit, input logic str_end,
                             input logic use_typed, input logic [2:0] n_typed,
                             input logic [47:0] typed_bytes);
        t_in_item  it;
        t_out_item ob;
        int        k;
        it.code_unit = unit;
        it.string_end = str_end;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_item <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        units_sent++;
        transcode_unit(it);
        if (use_typed) begin
            unit_bytes.delete();
            for (k = 0; k < n_typed; k++) add_byte(typed_bytes[47 - 8 * k -: 8]);
        end
        for (k = 0; k < unit_bytes.size(); k++) begin
            ob.utf8_byte = unit_bytes[k];
            ob.run_last = (k == unit_bytes.size() - 1);
            ob.string_last = ob.run_last && str_end;
            utf8_due.insert(utf8_due.size(), ob);
        end
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (utf8_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic sixteen);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data <= sixteen;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        mdl_sixteen = sixteen;
        mdl_held_high = '0;
        mdl_held_valid = 1'b0;
        mode_writes++;
    endtask

    task automatic send_random_utf16();
        int          kind;
        logic [31:0] u;
        logic [15:0] upper;
        logic        e;
        kind = $urandom_range(0, 99);
        e = ($urandom_range(0, 5) == 0);
        upper = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'h0;
        if (kind < 25) begin
            u = $urandom_range(0, 32'h7f);
        end else if (kind < 40) begin
            u = $urandom_range(32'h80, 32'h7ff);
        end else if (kind < 55) begin
            u = $urandom_range(0, 1) ? $urandom_range(32'h800, 32'hd7ff)
                                     : $urandom_range(32'he000, 32'hffff);
        end else if (kind < 82) begin
            send_item({upper, 16'($urandom_range(32'hd800, 32'hdbff))}, 1'b0,
                      1'b0, 3'd0, 48'h0);
            u = $urandom_range(32'hdc00, 32'hdfff);
        end else if (kind < 90) begin
            u = $urandom_range(32'hd800, 32'hdbff);
        end else if (kind < 95) begin
            u = $urandom_range(32'hdc00, 32'hdfff);
        end else begin
            u = $urandom;
            upper = u[31:16];
        end
        send_item({upper, u[15:0]}, e, 1'b0, 3'd0, 48'h0);
    endtask

    task automatic send_random_utf32();
        logic [31:0] u;
        case ($urandom_range(0, 7))
            0: u = $urandom_range(0, 32'h7f);
            1: u = $urandom_range(32'h80, 32'h7ff);
            2: u = $urandom_range(32'h800, 32'hffff);
            3: u = $urandom_range(32'h10000, 32'h10ffff);
            4: u = $urandom_range(32'hd800, 32'hdfff);
            5: u = $urandom_range(32'h110000, 32'h1fffff);
            6: u = $urandom;
            default: u = BOUNDARY_POINTS[$urandom_range(0, 9)];
        endcase
        send_item(u, $urandom_range(0, 4) == 0, 1'b0, 3'd0, 48'h0);
    endtask

    initial begin
        forever begin
            @(posedge clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_holds++;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && o_out_valid && out_ready) begin
            bytes_checked++;
            if (utf8_due.size() == 0) begin
                $display("%0t: unexpected byte, expected none, actual %h run_last %b str_last %b",
                         $time, o_out_item.utf8_byte, o_out_item.run_last,
                         o_out_item.string_last);
                mismatches++;
            end else begin
                want = utf8_due.pop_front();
                if (o_out_item.utf8_byte !== want.utf8_byte) begin
                    $display("%0t: utf8_byte expected %h actual %h",
                             $time, want.utf8_byte, o_out_item.utf8_byte);
                    mismatches++;
                end
                if (o_out_item.run_last !== want.run_last) begin
                    $display("%0t: run_last expected %b actual %b",
                             $time, want.run_last, o_out_item.run_last);
                    mismatches++;
                end
                if (o_out_item.string_last !== want.string_last) begin
                    $display("%0t: string_last expected %b actual %b",
                             $time, want.string_last, o_out_item.string_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int r;
        int target;
        mdl_sixteen = 1'b1;
        mdl_held_high = '0;
        mdl_held_valid = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, sender 19 / receiver 50
        for (r = 0; r < DIR_COUNT; r++) begin
            if (DIR_ROWS[r].is_cfg) begin
                write_mode(DIR_ROWS[r].unit[0]);
            end else begin
                send_item(DIR_ROWS[r].unit, DIR_ROWS[r].str_end, DIR_ROWS[r].typed,
                          DIR_ROWS[r].n_bytes, DIR_ROWS[r].bytes);
            end
        end

        target = units_sent + 100;
        while (units_sent < target) send_random_utf16();

        write_mode(1'b0);
        tx_idle_pct = 50;
        rx_idle_pct = 19;
        target = units_sent + 90;
        while (units_sent < target) send_random_utf32();

        write_mode(1'b1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        target = units_sent + 20;
        while (units_sent < target) send_random_utf16();
        // long receiver stall while the sender keeps pushing
        rx_hold_req = 1'b1;
        target = units_sent + 25;
        while (units_sent < target) send_random_utf16();
        wait_drain();
        target = units_sent + 25;
        while (units_sent < target) send_random_utf16();

        wait_drain();
        $display("covered %0d code units in utf-16 and utf-32 modes, %0d mode writes",
                 units_sent, mode_writes);
        $display("compared %0d utf-8 bytes, %0d long receiver stalls, %0d mismatches",
                 bytes_checked, rx_holds, mismatches);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
